FILE: hdl/lrupr_pkg.sv
package lrupr_pkg;

   localparam int FRAMES    = 16;
   localparam int PAGE_BITS = 20;
   localparam int TIME_BITS = 32;

   localparam int IDX_BITS      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_BITS      = $clog2(FRAMES + 1);
   localparam int CFG_BITS      = 5;
   localparam int IN_PAGE_BITS  = 20;
   localparam int OUT_IDX_BITS  = 4;
   localparam int TOTAL_BITS    = 32;

   localparam logic [CFG_BITS-1:0] FRAME_COUNT_RESET = 5'd16;
   localparam logic [63:0] TIME_MAX = 64'((65'd1 << TIME_BITS) - 65'd1);

   typedef logic [IDX_BITS-1:0]   lrupr_idx_type;
   typedef logic [CNT_BITS-1:0]   lrupr_cnt_type;
   typedef logic [PAGE_BITS-1:0]  lrupr_page_type;
   typedef logic [TIME_BITS-1:0]  lrupr_stamp_type;
   typedef logic [TOTAL_BITS-1:0] lrupr_total_type;

   typedef struct packed {
      logic            en;
      logic            page_en;
      lrupr_idx_type   addr;
      lrupr_page_type  page;
      lrupr_stamp_type stamp;
   } lrupr_wr_type;

   typedef struct packed {
      logic          match;
      logic          found;
      lrupr_idx_type slot;
   } lrupr_scan_type;

   function automatic lrupr_cnt_type frames_in_use(input logic [CFG_BITS-1:0] fc);
      lrupr_cnt_type r;
      if (fc == '0) begin
         r = CNT_BITS'(1);
      end else if (int'(fc) > FRAMES) begin
         r = CNT_BITS'(FRAMES);
      end else begin
         r = CNT_BITS'(fc);
      end
      return r;
   endfunction

   function automatic lrupr_stamp_type stamp_of(input lrupr_total_type cnt);
      lrupr_stamp_type r;
      if (64'(cnt) > TIME_MAX) begin
         r = TIME_BITS'(TIME_MAX);
      end else begin
         r = TIME_BITS'(cnt);
      end
      return r;
   endfunction

endpackage

FILE: hdl/lru_page_replacement.sv
// accepted request: frames in use are scanned from frame 0 and the scan stops
// at the first matching frame, then the table write and registered response follow
// one frame is compared per cycle in the shared scan unit; the block takes no new
// request until its response is registered, which waits while an earlier one is untaken
// synchronous reset: frames hold page 0 with time 0, counters clear, frame_count 16
module lru_page_replacement (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [lrupr_pkg::IN_PAGE_BITS-1:0]       req_page_number,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_hit,
   output logic [lrupr_pkg::OUT_IDX_BITS-1:0]       rsp_frame_index,
   output logic [lrupr_pkg::TOTAL_BITS-1:0]         rsp_request_total,
   output logic [lrupr_pkg::TOTAL_BITS-1:0]         rsp_fault_total,
   input  logic                                     csr_wr_en,
   input  logic [lrupr_pkg::CFG_BITS-1:0]           csr_wr_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_WRITE,
      S_OUT
   } state_type;

   state_type                          state_ff;
   lrupr_pkg::lrupr_cnt_type           idx_ff;
   lrupr_pkg::lrupr_cnt_type           n_ff;
   lrupr_pkg::lrupr_page_type          page_ff;
   lrupr_pkg::lrupr_total_type         req_cnt_ff;
   lrupr_pkg::lrupr_total_type         fault_cnt_ff;
   logic [lrupr_pkg::CFG_BITS-1:0]     frame_count_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_hit_ff;
   logic [lrupr_pkg::OUT_IDX_BITS-1:0] rsp_frame_index_ff;
   lrupr_pkg::lrupr_total_type         rsp_request_total_ff;
   lrupr_pkg::lrupr_total_type         rsp_fault_total_ff;

   lrupr_pkg::lrupr_wr_type    wr;
   lrupr_pkg::lrupr_scan_type  scan;
   lrupr_pkg::lrupr_page_type  rd_page;
   lrupr_pkg::lrupr_stamp_type rd_stamp;
   lrupr_pkg::lrupr_idx_type   rd_idx;
   logic                       last;

   assign rd_idx = idx_ff[lrupr_pkg::IDX_BITS-1:0];
   assign last   = (lrupr_pkg::CNT_BITS'(idx_ff + 1'b1) == n_ff);

   assign wr.en      = (state_ff == S_WRITE);
   assign wr.page_en = !scan.found;
   assign wr.addr    = scan.slot;
   assign wr.page    = page_ff;
   assign wr.stamp   = lrupr_pkg::stamp_of(req_cnt_ff);

   lrupr_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd_idx   (rd_idx),
      .rd_page  (rd_page),
      .rd_stamp (rd_stamp)
   );

   lrupr_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .clear    (state_ff == S_IDLE),
      .step     (state_ff == S_SCAN),
      .idx      (rd_idx),
      .ref_page (page_ff),
      .rd_page  (rd_page),
      .rd_stamp (rd_stamp),
      .status   (scan)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= S_IDLE;
         idx_ff               <= '0;
         n_ff                 <= '0;
         page_ff              <= '0;
         req_cnt_ff           <= '0;
         fault_cnt_ff         <= '0;
         frame_count_ff       <= lrupr_pkg::FRAME_COUNT_RESET;
         rsp_valid_ff         <= 1'b0;
         rsp_hit_ff           <= 1'b0;
         rsp_frame_index_ff   <= '0;
         rsp_request_total_ff <= '0;
         rsp_fault_total_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            frame_count_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  page_ff <= lrupr_pkg::PAGE_BITS'(req_page_number);
                  n_ff    <= lrupr_pkg::frames_in_use(frame_count_ff);
                  idx_ff  <= '0;
                  if (req_cnt_ff != '1) begin
                     req_cnt_ff <= req_cnt_ff + 1'b1;
                  end
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (scan.match || last) begin
                  state_ff <= S_WRITE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_WRITE: begin
               if (!scan.found && (fault_cnt_ff != '1)) begin
                  fault_cnt_ff <= fault_cnt_ff + 1'b1;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_hit_ff           <= scan.found;
                  rsp_frame_index_ff   <= lrupr_pkg::OUT_IDX_BITS'(scan.slot);
                  rsp_request_total_ff <= req_cnt_ff;
                  rsp_fault_total_ff   <= fault_cnt_ff;
                  state_ff             <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_index_ff;
   assign rsp_request_total = rsp_request_total_ff;
   assign rsp_fault_total   = rsp_fault_total_ff;

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (idx_ff < n_ff))
      else $error("scan index beyond frames in use");

   a_faults_bounded: assert property (@(posedge clock) disable iff (reset)
      fault_cnt_ff <= req_cnt_ff)
      else $error("fault count above request count");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_SCAN && idx_ff == '0))
      else $error("accepted request did not start a scan");

   a_hit_keeps_faults: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && scan.found) |=> $stable(fault_cnt_ff))
      else $error("fault count moved on a hit");

endmodule

FILE: hdl/lrupr_table.sv
module lrupr_table (
   input  logic                      clock,
   input  logic                      reset,
   input  lrupr_pkg::lrupr_wr_type   wr,
   input  lrupr_pkg::lrupr_idx_type  rd_idx,
   output lrupr_pkg::lrupr_page_type rd_page,
   output lrupr_pkg::lrupr_stamp_type rd_stamp
);

   lrupr_pkg::lrupr_page_type  page_ff  [lrupr_pkg::FRAMES];
   lrupr_pkg::lrupr_stamp_type stamp_ff [lrupr_pkg::FRAMES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
            page_ff[i]  <= '0;
            stamp_ff[i] <= '0;
         end
      end else if (wr.en) begin
         stamp_ff[wr.addr] <= wr.stamp;
         if (wr.page_en) begin
            page_ff[wr.addr] <= wr.page;
         end
      end
   end

   assign rd_page  = page_ff[rd_idx];
   assign rd_stamp = stamp_ff[rd_idx];

endmodule

FILE: hdl/lrupr_scan.sv
module lrupr_scan (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       step,
   input  lrupr_pkg::lrupr_idx_type   idx,
   input  lrupr_pkg::lrupr_page_type  ref_page,
   input  lrupr_pkg::lrupr_page_type  rd_page,
   input  lrupr_pkg::lrupr_stamp_type rd_stamp,
   output lrupr_pkg::lrupr_scan_type  status
);

   logic                       found_ff;
   logic                       first_ff;
   lrupr_pkg::lrupr_idx_type   match_idx_ff;
   lrupr_pkg::lrupr_idx_type   min_idx_ff;
   lrupr_pkg::lrupr_stamp_type min_stamp_ff;
   logic                       match_now;
   logic                       older;

   assign match_now = step && (rd_page == ref_page);
   assign older     = first_ff || (rd_stamp < min_stamp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         first_ff <= 1'b1;
      end else if (clear) begin
         found_ff <= 1'b0;
         first_ff <= 1'b1;
      end else if (step) begin
         first_ff <= 1'b0;
         if (match_now) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         if (match_now && !found_ff) begin
            match_idx_ff <= idx;
         end
         if (older) begin
            min_idx_ff   <= idx;
            min_stamp_ff <= rd_stamp;
         end
      end
   end

   assign status.match = match_now;
   assign status.found = found_ff;
   assign status.slot  = found_ff ? match_idx_ff : min_idx_ff;

endmodule

FILE: test/lru_replacement_checker.sv
module lru_replacement_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [lrupr_pkg::IN_PAGE_BITS-1:0] req_page_number,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               rsp_hit,
   input  logic [lrupr_pkg::OUT_IDX_BITS-1:0] rsp_frame_index,
   input  logic [lrupr_pkg::TOTAL_BITS-1:0]   rsp_request_total,
   input  logic [lrupr_pkg::TOTAL_BITS-1:0]   rsp_fault_total,
   input  logic                               csr_wr_en,
   input  logic [lrupr_pkg::CFG_BITS-1:0]     csr_wr_data,
   output int                                 errors,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                               hit;
      logic [lrupr_pkg::OUT_IDX_BITS-1:0] frame;
      lrupr_pkg::lrupr_total_type         requests;
      lrupr_pkg::lrupr_total_type         faults;
   } lookup_type;

   lrupr_pkg::lrupr_page_type  resident_page [lrupr_pkg::FRAMES];
   lrupr_pkg::lrupr_stamp_type last_touch [lrupr_pkg::FRAMES];
   lrupr_pkg::lrupr_total_type seen_requests;
   lrupr_pkg::lrupr_total_type seen_faults;
   logic [lrupr_pkg::CFG_BITS-1:0] frames_setting;
   lookup_type expected_lookups [$];
   int mismatches;

   function automatic lookup_type lookup_page(
      input logic [lrupr_pkg::IN_PAGE_BITS-1:0] raw);
      lrupr_pkg::lrupr_page_type  pg;
      lrupr_pkg::lrupr_stamp_type now;
      int                         scan;
      int                         slot;
      logic                       found;
      lookup_type                 r;
      pg = lrupr_pkg::PAGE_BITS'(raw);
      if (frames_setting == '0) begin
         scan = 1;
      end else if (int'(frames_setting) > lrupr_pkg::FRAMES) begin
         scan = lrupr_pkg::FRAMES;
      end else begin
         scan = int'(frames_setting);
      end
      if (seen_requests != '1) seen_requests++;
      if (64'(seen_requests) > lrupr_pkg::TIME_MAX) begin
         now = lrupr_pkg::TIME_BITS'(lrupr_pkg::TIME_MAX);
      end else begin
         now = lrupr_pkg::TIME_BITS'(seen_requests);
      end
      found = 1'b0;
      slot  = 0;
      for (int i = 0; i < scan; i++) begin
         if (!found && resident_page[i] == pg) begin
            found = 1'b1;
            slot  = i;
         end
      end
      if (!found) begin
         if (seen_faults != '1) seen_faults++;
         // oldest frame, lowest index on ties
         for (int i = 1; i < scan; i++) begin
            if (last_touch[i] < last_touch[slot]) slot = i;
         end
         resident_page[slot] = pg;
      end
      last_touch[slot] = now;
      r.hit      = found;
      r.frame    = lrupr_pkg::OUT_IDX_BITS'(slot);
      r.requests = seen_requests;
      r.faults   = seen_faults;
      return r;
   endfunction

   always @(posedge clock) begin
      lookup_type want;
      lookup_type predicted;
      if (reset) begin
         for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
            resident_page[i] = '0;
            last_touch[i]    = '0;
         end
         seen_requests  = '0;
         seen_faults    = '0;
         frames_setting = lrupr_pkg::FRAME_COUNT_RESET;
         expected_lookups.delete();
         mismatches = 0;
      end else begin
         if (csr_wr_en) frames_setting = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_lookups.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = expected_lookups.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
                  mismatches++;
               end
               if (rsp_frame_index !== want.frame) begin
                  $error("frame_index: expected %0d, got %0d", want.frame, rsp_frame_index);
                  mismatches++;
               end
               if (rsp_request_total !== want.requests) begin
                  $error("request_total: expected %0d, got %0d", want.requests,
                         rsp_request_total);
                  mismatches++;
               end
               if (rsp_fault_total !== want.faults) begin
                  $error("fault_total: expected %0d, got %0d", want.faults,
                         rsp_fault_total);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted = lookup_page(req_page_number);
            expected_lookups = {expected_lookups, predicted};
         end
      end
      pending <= expected_lookups.size();
      errors  <= mismatches;
   end

endmodule

FILE: test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 25;
   localparam int PHASES      = 14;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic [lrupr_pkg::IN_PAGE_BITS-1:0] req_page_number;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic                               rsp_hit;
   logic [lrupr_pkg::OUT_IDX_BITS-1:0] rsp_frame_index;
   logic [lrupr_pkg::TOTAL_BITS-1:0]   rsp_request_total;
   logic [lrupr_pkg::TOTAL_BITS-1:0]   rsp_fault_total;
   logic                               csr_wr_en;
   logic [lrupr_pkg::CFG_BITS-1:0]     csr_wr_data;
   int                                 errors;
   int                                 pending;
   int                                 cycle_count;
   int                                 tx_calm;
   int                                 rx_calm;
   int                                 frames_now;
   int                                 hot_size;
   logic [lrupr_pkg::IN_PAGE_BITS-1:0] hot_pages [32];

   lru_page_replacement i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_request_total (rsp_request_total),
      .rsp_fault_total   (rsp_fault_total),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   lru_replacement_checker i_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_request_total (rsp_request_total),
      .rsp_fault_total   (rsp_fault_total),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .errors            (errors),
      .pending           (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // random wait with occasional stretches of back-to-back traffic
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) calm = $urandom_range(5, 30);
      return $urandom_range(0, 7);
   endfunction

   function automatic logic [lrupr_pkg::IN_PAGE_BITS-1:0] pick_page();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return hot_pages[$urandom_range(0, hot_size - 1)];
      if (r < 69) return '0;
      if (r < 72) return '1;
      return lrupr_pkg::IN_PAGE_BITS'($urandom);
   endfunction

   task automatic refill_hot_pages();
      hot_size = frames_now + $urandom_range(0, 3);
      for (int i = 0; i < hot_size; i++) begin
         hot_pages[i] = $urandom_range(0, 1)
                        ? lrupr_pkg::IN_PAGE_BITS'($urandom)
                        : lrupr_pkg::IN_PAGE_BITS'($urandom_range(0, 40));
      end
   endtask

   task automatic send_page(input logic [lrupr_pkg::IN_PAGE_BITS-1:0] pg);
      int gap;
      gap = draw_wait(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_page_number <= pg;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait until every request has its response
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_frames(input int v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lrupr_pkg::CFG_BITS'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      frames_now = (v == 0) ? 1 : ((v > lrupr_pkg::FRAMES) ? lrupr_pkg::FRAMES : v);
   endtask

   initial begin
      rsp_ready = 1'b0;
      rx_calm   = 0;
      forever begin
         int gap;
         gap = draw_wait(rx_calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int phase_frames [PHASES];
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_page_number = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      tx_calm         = 0;
      frames_now      = lrupr_pkg::FRAMES;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty frames hold page 0, then extremes and lru order at reset setting
      send_page('0);
      send_page('1);
      send_page('0);
      send_page(20'h55555);
      send_page(20'hAAAAA);
      send_page(20'h00001);
      send_page(20'h80000);
      send_page('1);
      send_page(20'h00001);
      send_page(20'h55555);
      send_page(20'h12345);
      // single frame: every new page replaces frame 0
      write_frames(1);
      send_page(20'h12345);
      send_page(20'h12345);
      send_page('1);
      // zero treated as one frame, above range treated as all
      write_frames(0);
      send_page('1);
      send_page(20'h00002);
      write_frames(31);
      send_page(20'h55555);
      send_page(20'h12345);
      send_page('0);

      // frames above a shrunken count keep contents for when it grows back
      phase_frames = '{17, 4, 16, 2, 15, 3, 16, 0, 0, 0, 0, 0, 0, 0};
      for (int p = 7; p < PHASES; p++) begin
         phase_frames[p] = $urandom_range(0, 31);
      end
      foreach (phase_frames[p]) begin
         write_frames(phase_frames[p]);
         refill_hot_pages();
         repeat (58) begin
            if ($urandom_range(0, 39) == 0) drain();
            if ($urandom_range(0, 29) == 0) refill_hot_pages();
            send_page(pick_page());
         end
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
